/* rtl/u16u8_pkg.sv */
// Package for the UTF-16 to UTF-8 encoder: transaction types, byte job type,
// the fullwidth interval table and the encoding helper functions.
// No dependencies.
package u16u8_pkg;

   // Input transaction: one UTF-16 code unit
   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_type;

   // Output transaction: one UTF-8 byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } rsp_type;

   localparam int MAX_BYTES = 6;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   // Bytes caused by one code unit; entry 0 goes out first
   typedef struct packed {
      logic [CNT_W-1:0]               count;
      logic [MAX_BYTES-1:0][7:0]      bytes;
   } job_type;

   // Queue status seen by the front and back parts
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [15:0] ONE_BYTE_MAX  = 16'h007F;
   localparam logic [15:0] TWO_BYTE_MAX  = 16'h07FF;

   localparam int WIDE_COUNT = 97;

   localparam logic [20:0] WIDE_LO [WIDE_COUNT] = '{
      21'h01100, 21'h0231A, 21'h02329, 21'h023E9, 21'h023F0, 21'h023F3, 21'h025FD,
      21'h02614, 21'h02648, 21'h0267F, 21'h02693, 21'h026A1, 21'h026AA, 21'h026BD,
      21'h026C4, 21'h026CE, 21'h026D4, 21'h026EA, 21'h026F2, 21'h026F5, 21'h026FA,
      21'h026FD, 21'h02705, 21'h0270A, 21'h02728, 21'h0274C, 21'h0274E, 21'h02753,
      21'h02757, 21'h02795, 21'h027B0, 21'h027BF, 21'h02B1B, 21'h02B50, 21'h02B55,
      21'h02E80, 21'h02E9B, 21'h02F00, 21'h02FF0, 21'h03000, 21'h03041, 21'h04E00,
      21'h0A960, 21'h0AC00, 21'h0E000, 21'h0FE10, 21'h0FE30, 21'h0FF01, 21'h0FFE0,
      21'h16FE0, 21'h17000, 21'h18800, 21'h1B000, 21'h1F004, 21'h1F0CF, 21'h1F18E,
      21'h1F191, 21'h1F200, 21'h1F210, 21'h1F240, 21'h1F250, 21'h1F300, 21'h1F32D,
      21'h1F337, 21'h1F37E, 21'h1F3A0, 21'h1F3CF, 21'h1F3E0, 21'h1F3F4, 21'h1F3F8,
      21'h1F3FB, 21'h1F400, 21'h1F440, 21'h1F442, 21'h1F4FF, 21'h1F54B, 21'h1F550,
      21'h1F57A, 21'h1F595, 21'h1F5A4, 21'h1F5FB, 21'h1F600, 21'h1F680, 21'h1F6CC,
      21'h1F6D0, 21'h1F6EB, 21'h1F6F4, 21'h1F910, 21'h1F920, 21'h1F930, 21'h1F933,
      21'h1F940, 21'h1F950, 21'h1F980, 21'h1F9C0, 21'h20000, 21'h30000
   };

   localparam logic [20:0] WIDE_HI [WIDE_COUNT] = '{
      21'h0115F, 21'h0231B, 21'h0232A, 21'h023EC, 21'h023F0, 21'h023F3, 21'h025FE,
      21'h02615, 21'h02653, 21'h0267F, 21'h02693, 21'h026A1, 21'h026AB, 21'h026BE,
      21'h026C5, 21'h026CE, 21'h026D4, 21'h026EA, 21'h026F3, 21'h026F5, 21'h026FA,
      21'h026FD, 21'h02705, 21'h0270B, 21'h02728, 21'h0274C, 21'h0274E, 21'h02755,
      21'h02757, 21'h02797, 21'h027B0, 21'h027BF, 21'h02B1C, 21'h02B50, 21'h02B55,
      21'h02E99, 21'h02EF3, 21'h02FD5, 21'h02FFB, 21'h0303E, 21'h04DBF, 21'h0A4C6,
      21'h0A97C, 21'h0D7A3, 21'h0FAFF, 21'h0FE19, 21'h0FE6B, 21'h0FF60, 21'h0FFE6,
      21'h16FE0, 21'h187EC, 21'h18AF2, 21'h1B001, 21'h1F004, 21'h1F0CF, 21'h1F18E,
      21'h1F19A, 21'h1F202, 21'h1F23B, 21'h1F248, 21'h1F251, 21'h1F320, 21'h1F335,
      21'h1F37C, 21'h1F393, 21'h1F3CA, 21'h1F3D3, 21'h1F3F0, 21'h1F3F4, 21'h1F3FA,
      21'h1F3FF, 21'h1F43E, 21'h1F440, 21'h1F4FC, 21'h1F53D, 21'h1F54E, 21'h1F567,
      21'h1F57A, 21'h1F596, 21'h1F5A4, 21'h1F5FF, 21'h1F64F, 21'h1F6C5, 21'h1F6CC,
      21'h1F6D2, 21'h1F6EC, 21'h1F6F6, 21'h1F91E, 21'h1F927, 21'h1F930, 21'h1F93E,
      21'h1F94B, 21'h1F95E, 21'h1F991, 21'h1F9C0, 21'h2FFFD, 21'h3FFFD
   };

   // Check a code point against every fullwidth interval in parallel
   function automatic logic is_fullwidth(input logic [20:0] cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < WIDE_COUNT; i++) begin
         if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) hit = 1'b1;
      end
      return hit;
   endfunction

   // Three-byte form of a 16-bit value; entry 0 is the lead byte
   function automatic logic [2:0][7:0] enc3(input logic [15:0] v);
      logic [2:0][7:0] b;
      b[0] = {4'hE, v[15:12]};
      b[1] = {2'b10, v[11:6]};
      b[2] = {2'b10, v[5:0]};
      return b;
   endfunction

endpackage

/* rtl/utf16_to_utf8_pad_null_strip.sv */
// Top level of the UTF-16 to UTF-8 encoder with pad NUL removal.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
//
//   channel  ports                          transaction
//   input    req_push req_full req_data     one UTF-16 code unit
//   output   rsp_pop rsp_empty rsp_data     one UTF-8 byte
//   config   csr_valid csr_ready csr_data   strip_pad_nulls bit
//
// A code unit is taken every cycle while the job queue has room; it causes
// 0 to 6 bytes, and the back part sends one byte per cycle while rsp_pop is
// high, so the sustained rate is set by the output byte count. The first
// byte of a unit is visible once its job is written into the queue and then
// loaded into the back part. Synchronous reset clears state and sets
// strip_pad_nulls to 1. req_full rises only when QUEUE_DEPTH jobs are queued.
module utf16_to_utf8_pad_null_strip import u16u8_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic         strip_ff;
   q_status_type q_status;
   logic         job_push, job_pop;
   job_type      push_job, head_job;

   assign csr_ready = 1'b1;

   // Hold the padding removal enable
   always_ff @(posedge clock) begin
      if (reset) strip_ff <= 1'b1;
      else if (csr_valid && csr_ready) strip_ff <= csr_data;
   end

   u16u8_front u_front (
      .clock           (clock),
      .reset           (reset),
      .strip_pad_nulls (strip_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data        (req_data),
      .q_status        (q_status),
      .job_push        (job_push),
      .job_data        (push_job)
   );

   u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .pop       (job_pop),
      .head_data (head_job),
      .status    (q_status)
   );

   u16u8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_data (head_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/u16u8_front.sv */
// Front part of the UTF-16 to UTF-8 encoder: accepts code units, tracks the
// held high surrogate and the pad NUL swallow, builds the byte job.
// Depends on u16u8_pkg.
module u16u8_front import u16u8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         strip_pad_nulls,
   input  logic         req_push,
   output logic         req_full,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         job_push,
   output job_type      job_data
);

   logic        held_ff, held_in;
   logic [9:0]  bits_ff, bits_in;
   logic        skip_ff, skip_in;

   logic            accept;
   logic [15:0]     u;
   logic            is_low, is_high, pair, flush, pending;
   logic [20:0]     pair_cp, arm_cp;
   logic            arm_en;
   logic [2:0][7:0] tail, flush_b;
   logic [CNT_W-1:0] tail_cnt;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;
   assign u        = req_data.code_unit;

   // Classify the unit and build its bytes
   always_comb begin
      is_low   = (u[15:10] == LOW_SURR_TAG);
      is_high  = (u[15:10] == HIGH_SURR_TAG);
      pair     = held_ff && is_low;
      flush    = held_ff && !is_low;
      pending  = skip_ff && !held_ff;
      pair_cp  = {1'b0, bits_ff, u[9:0]} + SUPP_BASE;
      flush_b  = enc3({HIGH_SURR_TAG, bits_ff});
      tail     = '0;
      tail_cnt = '0;
      arm_en   = 1'b0;
      arm_cp   = {5'd0, u};
      held_in  = 1'b0;
      bits_in  = bits_ff;
      job_data = '0;

      priority if (pending && u == 16'd0) begin
         // drop the pad NUL
         tail_cnt = '0;
      end else if (u <= ONE_BYTE_MAX) begin
         tail[0]  = u[7:0];
         tail_cnt = CNT_W'(1);
      end else if (u <= TWO_BYTE_MAX) begin
         tail[0]  = {3'b110, u[10:6]};
         tail[1]  = {2'b10, u[5:0]};
         tail_cnt = CNT_W'(2);
      end else if (!is_high && !is_low) begin
         tail     = enc3(u);
         tail_cnt = CNT_W'(3);
         arm_en   = 1'b1;
      end else if (is_high && !req_data.last_unit) begin
         held_in  = 1'b1;
         bits_in  = u[9:0];
      end else begin
         tail     = enc3(u);
         tail_cnt = CNT_W'(3);
      end

      if (pair) begin
         held_in           = 1'b0;
         bits_in           = bits_ff;
         arm_en            = 1'b1;
         arm_cp            = pair_cp;
         job_data.count    = CNT_W'(4);
         job_data.bytes[0] = {5'b11110, pair_cp[20:18]};
         job_data.bytes[1] = {2'b10, pair_cp[17:12]};
         job_data.bytes[2] = {2'b10, pair_cp[11:6]};
         job_data.bytes[3] = {2'b10, pair_cp[5:0]};
      end else if (flush) begin
         job_data.count = tail_cnt + CNT_W'(3);
         job_data.bytes = {tail, flush_b};
      end else begin
         job_data.count = tail_cnt;
         job_data.bytes = {24'd0, tail};
      end

      skip_in = arm_en && strip_pad_nulls && is_fullwidth(arm_cp)
                && !req_data.last_unit;
      if (req_data.last_unit) held_in = 1'b0;
   end

   assign job_push = accept && (job_data.count != '0);

   // Advance the surrogate and swallow state on each accepted unit
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         bits_ff <= '0;
         skip_ff <= 1'b0;
      end else if (accept) begin
         held_ff <= held_in;
         bits_ff <= bits_in;
         skip_ff <= skip_in;
      end
   end

   a_held_skip_excl: assert property (@(posedge clock) disable iff (reset)
      !(held_ff && skip_ff))
      else $error("held surrogate and pending swallow both set");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_unit |=> !held_ff && !skip_ff)
      else $error("state not clean after last unit");

endmodule

/* rtl/u16u8_queue.sv */
// Short job queue between the front and back parts of the encoder.
// Depends on u16u8_pkg.
module u16u8_queue import u16u8_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_data,
   input  logic         pop,
   output job_type      head_data,
   output q_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type        mem_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == CW'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head_data    = mem_ff[rd_ff];

   // Wrap pointers and track fill level
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the job
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue underflow");

endmodule

/* rtl/u16u8_back.sv */
// Back part of the encoder: takes byte jobs from the queue and sends them out
// one byte per transaction. Depends on u16u8_pkg.
module u16u8_back import u16u8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  job_type      head_data,
   output logic         job_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_type      rsp_data
);

   logic                   busy_ff, busy_in;
   job_type                job_ff, job_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   last_byte, take;

   assign last_byte = (idx_ff == job_ff.count - CNT_W'(1));
   assign take      = rsp_pop && busy_ff;
   assign job_pop   = !q_status.empty && (!busy_ff || (take && last_byte));
   assign rsp_empty = !busy_ff;

   assign rsp_data.out_byte = job_ff.bytes[idx_ff];
   assign rsp_data.run_end  = last_byte;

   // Load the next job or advance through the current one
   always_comb begin
      busy_in = busy_ff;
      job_in  = job_ff;
      idx_in  = idx_ff;
      if (job_pop) begin
         busy_in = 1'b1;
         job_in  = head_data;
         idx_in  = '0;
      end else if (take) begin
         if (last_byte) busy_in = 1'b0;
         else idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (job_ff.count != '0) && (idx_ff < job_ff.count))
      else $error("byte index outside current job");

endmodule
